// ===== sv/per_task_deadline_watchdog_unit_defines.svh =====
// ---------------------------------------------------------------------------
// Assertion macros for the task deadline watchdog
// Shared implication checks, clocked on clk and quiet during reset.
// ---------------------------------------------------------------------------
`ifndef PER_TASK_DEADLINE_WATCHDOG_UNIT_DEFINES_SVH
`define PER_TASK_DEADLINE_WATCHDOG_UNIT_DEFINES_SVH

// same-cycle implication
`define PTDW_ASSERT_IMP(label, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error("watchdog assertion failed");

// next-cycle implication
`define PTDW_ASSERT_NXT(label, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error("watchdog assertion failed");

`endif

// ===== sv/ptdw_pkg.sv =====
// ---------------------------------------------------------------------------
// ptdw_pkg
// Types and constants for the task deadline watchdog.
// ---------------------------------------------------------------------------
package ptdw_pkg;

	localparam int TIME_W = 32;
	localparam int CNT_W  = 16;
	localparam int IDX_W  = 2;

	// register indexes on the config port
	localparam logic [IDX_W-1:0] REG_DEADLINE_SLOT0 = 2'd0;
	localparam logic [IDX_W-1:0] REG_DEADLINE_SLOT1 = 2'd1;
	localparam logic [IDX_W-1:0] REG_POLL_PERIOD    = 2'd2;

	// reset values
	localparam logic [TIME_W-1:0] DEADLINE0_RST = 32'd2000;
	localparam logic [TIME_W-1:0] DEADLINE1_RST = 32'd4000;
	localparam logic [CNT_W-1:0]  POLL_RST      = 16'd500;

	// input word kinds
	localparam logic ACT_TICK    = 1'b0;
	localparam logic ACT_CHECKIN = 1'b1;

	// expired slot code when nothing expired
	localparam logic [1:0] SLOT_NONE = 2'd2;

	// result of one deadline check
	typedef struct packed {
		logic       hit;
		logic [1:0] slot;
	} chk_res_t;

endpackage

// ===== sv/ptdw_check.sv =====
// ---------------------------------------------------------------------------
// ptdw_check
// Compares elapsed time per slot against its deadline; first expiry wins.
// ---------------------------------------------------------------------------
module ptdw_check
	import ptdw_pkg::*;
#(
	parameter int NUM_SLOTS = 2
) (
	input  logic [TIME_W-1:0]                 time_now,
	input  logic [NUM_SLOTS-1:0][TIME_W-1:0]  stamp,
	input  logic [NUM_SLOTS-1:0][TIME_W-1:0]  deadline,
	output chk_res_t                          res
);

	logic [NUM_SLOTS-1:0] late;

	// elapsed time wraps modulo 2^32
	always_comb begin
		for (int i = 0; i < NUM_SLOTS; i++) begin
			late[i] = (time_now - stamp[i]) > deadline[i];
		end
	end

	// lowest expired slot takes priority
	always_comb begin
		res.hit  = 1'b0;
		res.slot = SLOT_NONE;
		for (int i = NUM_SLOTS - 1; i >= 0; i--) begin
			if (late[i]) begin
				res.hit  = 1'b1;
				res.slot = 2'(i);
			end
		end
	end

endmodule

// ===== sv/per_task_deadline_watchdog_unit.sv =====
// ---------------------------------------------------------------------------
// per_task_deadline_watchdog_unit
// Multi-slot task watchdog: time base, check-in stamps and periodic checks.
// ---------------------------------------------------------------------------
// Input channel (s_*): one word per event. tuser picks the kind: a tick
// advances the millisecond time and the poll countdown, a check-in stamps
// the slot in tdata with the current time.
// Output channel (m_*): exactly one result word per input word, in order:
// whether a check ran, the refresh pulse, the first expired slot (2 = none)
// and the sticky error flag.
// Config port: cfg_wr_en/cfg_index/cfg_wdata write the slot deadlines and
// the poll period; write only while no words are in flight. A new poll
// period applies at the next countdown reload.
// Each word passes the input register, then the result register fed by
// one compare per slot.
// Throughput: one word per cycle; the result register frees each cycle it
// is taken, and the input stage holds its word while the receiver stalls,
// so s_tready drops only when both stages are full.
// Reset: time, stamps and error flag clear, countdown loads 500, deadlines
// load 2000 and 4000; both stages empty.
// ---------------------------------------------------------------------------
`include "per_task_deadline_watchdog_unit_defines.svh"

module per_task_deadline_watchdog_unit
	import ptdw_pkg::*;
#(
	parameter int NUM_SLOTS = 2
) (
	input  logic              clk,
	input  logic              arst_n,
	// config write port
	input  logic              cfg_wr_en,
	input  logic [IDX_W-1:0]  cfg_index,
	input  logic [TIME_W-1:0] cfg_wdata,
	// input words
	input  logic              s_tvalid,
	output logic              s_tready,
	input  logic [7:0]        s_tdata,   // [0] slot, [7:1] zero
	input  logic [0:0]        s_tuser,   // [0] action
	// result words
	output logic              m_tvalid,
	input  logic              m_tready,
	output logic [7:0]        m_tdata    // [0] checked, [1] refresh,
	                                     // [3:2] expired_slot, [4] error_flag
);

	// config registers
	logic [TIME_W-1:0] deadline0_q, deadline1_q;
	logic [CNT_W-1:0]  poll_period_q;

	// watchdog state
	logic [TIME_W-1:0]                time_q;
	logic [NUM_SLOTS-1:0][TIME_W-1:0] stamp_q;
	logic [CNT_W-1:0]                 cnt_q;
	logic                             err_q;

	// pipeline
	logic valid_s1, action_s1, slot_s1;
	logic valid_s2, checked_s2, refresh_s2, err_s2;
	logic [1:0] expired_s2;

	logic advance, proc, tick, check_now;
	logic [TIME_W-1:0] time_nxt;
	logic [NUM_SLOTS-1:0][TIME_W-1:0] deadline;
	chk_res_t chk;

	// handshake
	assign advance  = !valid_s2 || m_tready;
	assign s_tready = !valid_s1 || advance;
	assign proc     = valid_s1 && advance;
	assign tick     = action_s1 == ACT_TICK;
	assign check_now = tick && (cnt_q <= 16'd1);
	assign time_nxt = time_q + 32'd1;

	// per-slot deadline select
	for (genvar g = 0; g < NUM_SLOTS; g++) begin : g_dl
		if (g == 0) begin : g_first
			assign deadline[g] = deadline0_q;
		end else begin : g_other
			assign deadline[g] = deadline1_q;
		end
	end

	ptdw_check #(.NUM_SLOTS(NUM_SLOTS)) u_check (
		.time_now (time_nxt),
		.stamp    (stamp_q),
		.deadline (deadline),
		.res      (chk)
	);

	// config writes
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			deadline0_q   <= DEADLINE0_RST;
			deadline1_q   <= DEADLINE1_RST;
			poll_period_q <= POLL_RST;
		end else if (cfg_wr_en) begin
			case (cfg_index)
				REG_DEADLINE_SLOT0: deadline0_q   <= cfg_wdata;
				REG_DEADLINE_SLOT1: deadline1_q   <= cfg_wdata;
				REG_POLL_PERIOD:    poll_period_q <= cfg_wdata[CNT_W-1:0];
				default: ;
			endcase
		end
	end

	// input stage
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (s_tready) begin
			valid_s1 <= s_tvalid;
		end
	end

	always_ff @(posedge clk) begin
		if (s_tready && s_tvalid) begin
			action_s1 <= s_tuser[0];
			slot_s1   <= s_tdata[0];
		end
	end

	// time, countdown and error state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			time_q <= '0;
			cnt_q  <= POLL_RST;
			err_q  <= 1'b0;
		end else if (proc && tick) begin
			time_q <= time_nxt;
			cnt_q  <= check_now ? poll_period_q : cnt_q - 16'd1;
			if (check_now && chk.hit) begin
				err_q <= 1'b1;
			end
		end
	end

	// check-in stamps
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			stamp_q <= '0;
		end else if (proc && !tick) begin
			for (int i = 0; i < NUM_SLOTS; i++) begin
				if (slot_s1 == 1'(i)) begin
					stamp_q[i] <= time_q;
				end
			end
		end
	end

	// result stage
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s2 <= 1'b0;
		end else if (advance) begin
			valid_s2 <= valid_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (proc) begin
			checked_s2 <= check_now;
			refresh_s2 <= check_now && !chk.hit;
			expired_s2 <= (check_now && chk.hit) ? chk.slot : SLOT_NONE;
			err_s2     <= err_q || (check_now && chk.hit);
		end
	end

	assign m_tvalid = valid_s2;
	assign m_tdata  = {3'b000, err_s2, expired_s2, refresh_s2, checked_s2};

	// checks
	`PTDW_ASSERT_IMP(a_refresh_clean, valid_s2 && refresh_s2,
		checked_s2 && expired_s2 == SLOT_NONE)
	`PTDW_ASSERT_IMP(a_expiry_sets_err, valid_s2 && expired_s2 != SLOT_NONE,
		checked_s2 && err_s2)
	`PTDW_ASSERT_NXT(a_err_sticky, err_q, err_q)
	`PTDW_ASSERT_NXT(a_cnt_dec, proc && tick && cnt_q > 16'd1,
		cnt_q == $past(cnt_q) - 16'd1)

endmodule
